### hw/rtl/tbpf_pkg.sv
`default_nettype none
package tbpf_pkg;

	localparam int VRAM_HALFWORDS = 32768;
	localparam int VRAM_AW        = $clog2(VRAM_HALFWORDS);
	localparam logic [15:0] VRAM_LIMIT = 16'(VRAM_HALFWORDS);
	localparam int PAL_ENTRIES    = 256;
	localparam int PAL_AW         = $clog2(PAL_ENTRIES);
	localparam int QDEPTH         = 2;
	localparam int QAW            = $clog2(QDEPTH);
	localparam int PADDR_W        = 5;

	localparam logic [1:0] KIND_QUERY   = 2'd0;
	localparam logic [1:0] KIND_VRAM_WR = 2'd1;
	localparam logic [1:0] KIND_PAL_WR  = 2'd2;

	localparam logic [1:0] REG_BG_CONTROLS = 2'd0;
	localparam logic [1:0] REG_SCROLL_X    = 2'd1;
	localparam logic [1:0] REG_SCROLL_Y    = 2'd2;
	localparam logic [1:0] REG_MOSAIC      = 2'd3;

	// ceil(65536 / n) for mosaic block sizes n = 1..16; exact floor for 8-bit coordinates
	localparam logic [16:0] MOSAIC_RECIP [16] = '{
		17'd65536, 17'd32768, 17'd21846, 17'd16384,
		17'd13108, 17'd10923, 17'd9363,  17'd8192,
		17'd7282,  17'd6554,  17'd5958,  17'd5462,
		17'd5042,  17'd4682,  17'd4370,  17'd4096
	};

	typedef struct packed {
		logic [3:0][15:0] bg_controls;
		logic [3:0][8:0]  scroll_x;
		logic [3:0][8:0]  scroll_y;
		logic [7:0]       mosaic;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VRAM_AW-1:0] addr;
		logic [15:0]        wdata;
		logic [2:0]         cx;
		logic [2:0]         cy;
		logic [1:0]         prio;
		logic [1:0]         tile_base;
		logic               wide;
		logic [7:0]         px;
		logic [7:0]         py;
	} q_entry_t;

	typedef struct packed {
		logic [15:0] color;
		logic        opaque;
		logic [1:0]  prio;
		logic [7:0]  x;
		logic [7:0]  y;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/tbpf_ram.sv
`default_nettype none
module tbpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tbpf_front.sv
`default_nettype none
module tbpf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tbpf_pkg::cfg_t     cfg,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [1:0]         bg_select,
	input  wire logic [7:0]         pixel_x,
	input  wire logic [7:0]         pixel_y,
	input  wire logic [14:0]        write_address,
	input  wire logic [15:0]        write_data,
	output logic                    push,
	output tbpf_pkg::q_entry_t      push_data,
	input  wire logic               full
);
	import tbpf_pkg::*;

	logic        valid_s1, valid_s2;
	logic        adv2, accept, keep;
	logic [1:0]  kind_s1, bg_s1;
	logic [7:0]  px_s1, py_s1;
	logic [14:0] waddr_s1;
	logic [15:0] wdata_s1;

	logic [1:0]  kind_s2;
	logic [7:0]  px_s2, py_s2, qx_s2, qy_s2;
	logic [14:0] waddr_s2;
	logic [15:0] wdata_s2, ctl_s2;
	logic [8:0]  scx_s2, scy_s2;
	logic [4:0]  sx_s2, sy_s2;

	logic [24:0] prod_x, prod_y;
	logic [12:0] org_x, org_y;
	logic [7:0]  ox, oy;
	logic [8:0]  lx, ly;
	logic [1:0]  size;
	logic [5:0]  block;
	logic [15:0] entry_addr;

	assign push   = valid_s2 && !full;
	assign adv2   = !valid_s2 || push;
	assign busy   = valid_s1 && !adv2;
	assign accept = start && !busy;

	// drop unknown kinds and video writes past the end of memory
	assign keep = (kind_s1 == KIND_QUERY) || (kind_s1 == KIND_PAL_WR) ||
		((kind_s1 == KIND_VRAM_WR) && ({1'b0, waddr_s1} < VRAM_LIMIT));

	// quotient of coordinate by mosaic size through the reciprocal table
	assign prod_x = 25'(px_s1) * 25'(MOSAIC_RECIP[cfg.mosaic[3:0]]);
	assign prod_y = 25'(py_s1) * 25'(MOSAIC_RECIP[cfg.mosaic[7:4]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= valid_s1 && keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			bg_s1    <= bg_select;
			px_s1    <= pixel_x;
			py_s1    <= pixel_y;
			waddr_s1 <= write_address;
			wdata_s1 <= write_data;
		end
		if (adv2 && valid_s1) begin
			kind_s2  <= kind_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			ctl_s2   <= cfg.bg_controls[bg_s1];
			scx_s2   <= cfg.scroll_x[bg_s1];
			scy_s2   <= cfg.scroll_y[bg_s1];
			qx_s2    <= prod_x[23:16];
			qy_s2    <= prod_y[23:16];
			sx_s2    <= {1'b0, cfg.mosaic[3:0]} + 5'd1;
			sy_s2    <= {1'b0, cfg.mosaic[7:4]} + 5'd1;
		end
	end

	assign org_x = 13'(qx_s2) * 13'(sx_s2);
	assign org_y = 13'(qy_s2) * 13'(sy_s2);
	assign ox    = ctl_s2[6] ? org_x[7:0] : px_s2;
	assign oy    = ctl_s2[6] ? org_y[7:0] : py_s2;
	assign size  = ctl_s2[15:14];

	always_comb begin
		lx = {1'b0, ox} + scx_s2;
		ly = {1'b0, oy} + scy_s2;
		lx[8] = lx[8] & size[0];
		ly[8] = ly[8] & size[1];
	end

	// a wide map has two blocks per row
	assign block = {1'b0, ctl_s2[12:8]} +
		(size[0] ? {4'b0, ly[8], 1'b0} : {5'b0, ly[8]}) + {5'b0, lx[8]};
	assign entry_addr = {block, ly[7:3], lx[7:3]};

	always_comb begin
		push_data.kind      = kind_s2;
		push_data.addr      = (kind_s2 == KIND_QUERY) ? entry_addr[VRAM_AW-1:0]
			: waddr_s2[VRAM_AW-1:0];
		push_data.wdata     = wdata_s2;
		push_data.cx        = lx[2:0];
		push_data.cy        = ly[2:0];
		push_data.prio      = ctl_s2[1:0];
		push_data.tile_base = ctl_s2[3:2];
		push_data.wide      = ctl_s2[7];
		push_data.px        = px_s2;
		push_data.py        = py_s2;
	end

endmodule
`default_nettype wire

### hw/rtl/tbpf_queue.sv
`default_nettype none
module tbpf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tbpf_pkg::q_entry_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output tbpf_pkg::q_entry_t      head,
	output logic                    empty
);
	import tbpf_pkg::*;

	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tbpf_back.sv
`default_nettype none
module tbpf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tbpf_pkg::q_entry_t head,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    done,
	output tbpf_pkg::result_t       result
);
	import tbpf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_TILE = 4'b0010,
		S_PAL  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t   state_q;
	q_entry_t cur_q;
	logic [3:0] bank_q;
	logic       byte_sel_q, nib_sel_q, opaque_q, done_q;
	result_t    result_q;

	logic               vram_we, vram_re, pal_we, pal_re;
	logic [VRAM_AW-1:0] vram_raddr;
	logic [15:0]        vram_rdata, pal_rdata;
	logic [PAL_AW-1:0]  pal_raddr;

	logic [2:0]  cx, cy;
	logic [15:0] off8, off4;
	logic [16:0] tile_byte;
	logic [7:0]  pix_byte, cidx, pal_idx;
	logic [3:0]  nib;

	assign pop = (state_q == S_IDLE) && !empty;

	// map entry arrives in S_TILE: apply flips and form the tile byte address
	assign cx   = cur_q.cx ^ {3{vram_rdata[10]}};
	assign cy   = cur_q.cy ^ {3{vram_rdata[11]}};
	assign off8 = {vram_rdata[9:0], cy, cx};
	assign off4 = {1'b0, vram_rdata[9:0], cy, cx[2:1]};
	assign tile_byte = {1'b0, cur_q.tile_base, 14'b0} +
		{1'b0, cur_q.wide ? off8 : off4};

	// tile halfword arrives in S_PAL: pick the byte, then the nibble
	assign pix_byte = byte_sel_q ? vram_rdata[15:8] : vram_rdata[7:0];
	assign nib      = nib_sel_q ? pix_byte[7:4] : pix_byte[3:0];
	assign cidx     = cur_q.wide ? pix_byte : {4'b0, nib};
	assign pal_idx  = cur_q.wide ? pix_byte : {bank_q, nib};

	always_comb begin
		vram_we    = 1'b0;
		vram_re    = 1'b0;
		pal_we     = 1'b0;
		pal_re     = 1'b0;
		vram_raddr = head.addr;
		pal_raddr  = pal_idx[PAL_AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					vram_we = (head.kind == KIND_VRAM_WR);
					pal_we  = (head.kind == KIND_PAL_WR);
					vram_re = (head.kind == KIND_QUERY);
				end
			end
			S_TILE: begin
				vram_re    = 1'b1;
				vram_raddr = tile_byte[VRAM_AW:1];
			end
			S_PAL: begin
				pal_re = 1'b1;
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT);
			unique case (state_q)
				S_IDLE: begin
					if (pop && head.kind == KIND_QUERY) begin
						state_q <= S_TILE;
					end
				end
				S_TILE:  state_q <= S_PAL;
				S_PAL:   state_q <= S_OUT;
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == S_TILE) begin
			bank_q     <= vram_rdata[15:12];
			byte_sel_q <= tile_byte[0];
			nib_sel_q  <= cx[0];
		end
		if (state_q == S_PAL) begin
			opaque_q <= (cidx != 8'd0);
		end
		if (state_q == S_OUT) begin
			result_q.color  <= opaque_q ? pal_rdata : 16'd0;
			result_q.opaque <= opaque_q;
			result_q.prio   <= cur_q.prio;
			result_q.x      <= cur_q.px;
			result_q.y      <= cur_q.py;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	tbpf_ram #(.WIDTH(16), .DEPTH(VRAM_HALFWORDS)) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (head.addr),
		.wdata (head.wdata),
		.re    (vram_re),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	tbpf_ram #(.WIDTH(16), .DEPTH(PAL_ENTRIES)) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (head.addr[PAL_AW-1:0]),
		.wdata (head.wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

endmodule
`default_nettype wire

### hw/rtl/tiled_background_pixel_fetch.sv
`default_nettype none
// Tiled background pixel fetch. An item is taken at a clock edge with start high and busy
// low; kind selects a pixel query, a video memory halfword write or a palette write. Items
// pass a two-stage front end (mosaic snap, scroll and map address) into a two-entry queue,
// then a back end that runs them in order against the video memory and palette RAMs. A
// write is done as it leaves the queue; a pixel query passes four back-end steps: its
// three dependent reads (map entry, tile halfword, palette color) on the single read port
// of each RAM, then the result register. The back end takes no new item until a query is
// through. A result is shown for exactly one cycle with done high; the receiver cannot
// stall it, so it must take every result in that cycle. Write items and unknown kinds give
// no result. Both memories start undefined and need no clearing; query only entries that
// were written. Registers sit at byte addresses 0, 8, 16 and 24 on the 64-bit APB port.
// The user must write them only while no item is in flight; the block itself does not
// enforce this.
module tiled_background_pixel_fetch (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    kind,
	input  wire logic [1:0]                    bg_select,
	input  wire logic [7:0]                    pixel_x,
	input  wire logic [7:0]                    pixel_y,
	input  wire logic [14:0]                   write_address,
	input  wire logic [15:0]                   write_data,
	output logic                               done,
	output logic [15:0]                        color,
	output logic                               opaque,
	output logic [1:0]                         layer_priority,
	output logic [7:0]                         out_x,
	output logic [7:0]                         out_y,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbpf_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [63:0]                   pwdata,
	output logic [63:0]                        prdata,
	output logic                               pready
);
	import tbpf_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       push, full, pop, empty;
	q_entry_t   push_data, head;
	result_t    result;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BG_CONTROLS: cfg_q.bg_controls <= pwdata;
				REG_SCROLL_X:    cfg_q.scroll_x    <= pwdata[35:0];
				REG_SCROLL_Y:    cfg_q.scroll_y    <= pwdata[35:0];
				REG_MOSAIC:      cfg_q.mosaic      <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BG_CONTROLS: prdata = cfg_q.bg_controls;
			REG_SCROLL_X:    prdata = {28'b0, cfg_q.scroll_x};
			REG_SCROLL_Y:    prdata = {28'b0, cfg_q.scroll_y};
			REG_MOSAIC:      prdata = {56'b0, cfg_q.mosaic};
			default:         prdata = '0;
		endcase
	end

	tbpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.bg_select     (bg_select),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.write_address (write_address),
		.write_data    (write_data),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	tbpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tbpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	assign color          = result.color;
	assign opaque         = result.opaque;
	assign layer_priority = result.prio;
	assign out_x          = result.x;
	assign out_y          = result.y;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

import tbpf_pkg::*;

class pixel_scoreboard;
	logic [15:0] vram [VRAM_HALFWORDS];
	bit          vram_valid [VRAM_HALFWORDS];
	logic [15:0] palette [PAL_ENTRIES];
	bit          palette_valid [PAL_ENTRIES];
	logic [63:0] bg_ctl;
	logic [35:0] scroll_x;
	logic [35:0] scroll_y;
	logic [7:0]  mosaic;
	result_t     pending_pixels [$];
	int          mismatches;

	function new();
		bg_ctl = '0;
		scroll_x = '0;
		scroll_y = '0;
		mosaic = '0;
		mismatches = 0;
	endfunction

	function void set_reg(input logic [1:0] idx, input logic [63:0] value);
		case (idx)
			REG_BG_CONTROLS: bg_ctl = value;
			REG_SCROLL_X:    scroll_x = value[35:0];
			REG_SCROLL_Y:    scroll_y = value[35:0];
			REG_MOSAIC:      mosaic = value[7:0];
		endcase
	endfunction

	function logic [63:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_BG_CONTROLS: return bg_ctl;
			REG_SCROLL_X:    return 64'(scroll_x);
			REG_SCROLL_Y:    return 64'(scroll_y);
			default:         return 64'(mosaic);
		endcase
	endfunction

	function void check_reg(input logic [1:0] idx, input logic [63:0] got);
		if (got !== reg_value(idx)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d readback: expected %h, got %h", idx, reg_value(idx), got);
		end
	endfunction

	// Walk the fetch path of one pixel. Returns 0 at the first store entry that would be
	// read before it was written, and names that entry.
	function bit render_pixel(input logic [1:0] bg, input logic [7:0] px, input logic [7:0] py,
			output result_t res, output bit gap_pal, output int gap_addr, output int map_addr);
		logic [15:0] ctl;
		logic [15:0] entry;
		logic [15:0] hw_data;
		logic [2:0]  cx;
		logic [2:0]  cy;
		logic [7:0]  tbyte;
		logic [3:0]  nib;
		bit          clear;
		int          ux, uy, msx, msy, blk, byte_addr, hw, pal_idx;
		ctl = bg_ctl[16*bg +: 16];
		res = '0;
		res.prio = ctl[1:0];
		res.x = px;
		res.y = py;
		gap_pal = 1'b0;
		gap_addr = 0;
		ux = int'(px);
		uy = int'(py);
		if (ctl[6]) begin
			// snap down to the origin of the mosaic block
			msx = int'(mosaic[3:0]) + 1;
			msy = int'(mosaic[7:4]) + 1;
			ux -= ux % msx;
			uy -= uy % msy;
		end
		ux = (ux + int'(scroll_x[9*bg +: 9])) & (ctl[14] ? 'h1FF : 'hFF);
		uy = (uy + int'(scroll_y[9*bg +: 9])) & (ctl[15] ? 'h1FF : 'hFF);
		blk = int'(ctl[12:8]) + (ctl[14] ? 2 : 1) * (uy >> 8) + (ux >> 8);
		map_addr = (blk * 1024 + ((uy & 'hFF) >> 3) * 32 + ((ux & 'hFF) >> 3)) % VRAM_HALFWORDS;
		if (!vram_valid[map_addr]) begin
			gap_addr = map_addr;
			return 1'b0;
		end
		entry = vram[map_addr];
		cx = entry[10] ? 3'(7 - (ux & 7)) : 3'(ux & 7);
		cy = entry[11] ? 3'(7 - (uy & 7)) : 3'(uy & 7);
		if (ctl[7])
			byte_addr = int'(ctl[3:2]) * 16384 + int'(entry[9:0]) * 64 + int'(cy) * 8
				+ int'(cx);
		else
			byte_addr = int'(ctl[3:2]) * 16384 + int'(entry[9:0]) * 32 + int'(cy) * 4
				+ int'(cx[2:1]);
		hw = (byte_addr >> 1) % VRAM_HALFWORDS;
		if (!vram_valid[hw]) begin
			gap_addr = hw;
			return 1'b0;
		end
		hw_data = vram[hw];
		tbyte = byte_addr[0] ? hw_data[15:8] : hw_data[7:0];
		if (ctl[7]) begin
			clear = (tbyte == 8'd0);
			pal_idx = int'(tbyte);
		end else begin
			nib = cx[0] ? tbyte[7:4] : tbyte[3:0];
			clear = (nib == 4'd0);
			pal_idx = int'({entry[15:12], nib});
		end
		if (clear)
			return 1'b1;
		if (!palette_valid[pal_idx]) begin
			gap_pal = 1'b1;
			gap_addr = pal_idx;
			return 1'b0;
		end
		res.color = palette[pal_idx];
		res.opaque = 1'b1;
		return 1'b1;
	endfunction

	function void note_item(input logic [1:0] item_kind, input logic [1:0] bg,
			input logic [7:0] px, input logic [7:0] py, input logic [14:0] waddr,
			input logic [15:0] wdata);
		result_t res;
		bit      gap_pal;
		int      gap_addr, map_addr;
		case (item_kind)
			KIND_VRAM_WR: begin
				if (int'(waddr) < VRAM_HALFWORDS) begin
					vram[waddr] = wdata;
					vram_valid[waddr] = 1'b1;
				end
			end
			KIND_PAL_WR: begin
				palette[waddr[7:0]] = wdata;
				palette_valid[waddr[7:0]] = 1'b1;
			end
			KIND_QUERY: begin
				void'(render_pixel(bg, px, py, res, gap_pal, gap_addr, map_addr));
				pending_pixels.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function void check_pixel(input result_t got);
		result_t want;
		if (pending_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("pixel result with none pending: color %h opaque %b prio %0d at (%0d,%0d)",
					got.color, got.opaque, got.prio, got.x, got.y);
			return;
		end
		want = pending_pixels.pop_front();
		if (got.color !== want.color || got.opaque !== want.opaque || got.prio !== want.prio
				|| got.x !== want.x || got.y !== want.y) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("pixel mismatch: expected color %h opaque %b prio %0d at (%0d,%0d)",
					want.color, want.opaque, want.prio, want.x, want.y);
				$display("                got color %h opaque %b prio %0d at (%0d,%0d)",
					got.color, got.opaque, got.prio, got.x, got.y);
			end
		end
	endfunction

	function void close_out();
		if (pending_pixels.size() > 0) begin
			$display("%0d pixel results never arrived", pending_pixels.size());
			mismatches += pending_pixels.size();
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         kind = '0;
	logic [1:0]         bg_select = '0;
	logic [7:0]         pixel_x = '0;
	logic [7:0]         pixel_y = '0;
	logic [14:0]        write_address = '0;
	logic [15:0]        write_data = '0;
	logic               done;
	logic [15:0]        color;
	logic               opaque;
	logic [1:0]         layer_priority;
	logic [7:0]         out_x;
	logic [7:0]         out_y;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;

	pixel_scoreboard sb = new();
	int              items_sent = 0;
	bit              no_idle = 1'b0;
	logic [1:0]      last_bg = '0;
	logic [7:0]      last_x = '0;
	logic [7:0]      last_y = '0;

	tiled_background_pixel_fetch i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.bg_select      (bg_select),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.write_address  (write_address),
		.write_data     (write_data),
		.done           (done),
		.color          (color),
		.opaque         (opaque),
		.layer_priority (layer_priority),
		.out_x          (out_x),
		.out_y          (out_y),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel({color, opaque, layer_priority, out_x, out_y});
	end

	task automatic send_item(input logic [1:0] k, input logic [1:0] bg, input logic [7:0] px,
			input logic [7:0] py, input logic [14:0] wa, input logic [15:0] wd);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			// junk on an idle bus must be ignored
			kind <= 2'($urandom);
			bg_select <= 2'($urandom);
			pixel_x <= 8'($urandom);
			pixel_y <= 8'($urandom);
			write_address <= 15'($urandom);
			write_data <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		bg_select <= bg;
		pixel_x <= px;
		pixel_y <= py;
		write_address <= wa;
		write_data <= wd;
		do @(posedge clk); while (busy);
		sb.note_item(k, bg, px, py, wa, wd);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic drain_items;
		int waited;
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (sb.pending_pixels.size() > 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		// writes behind the last query may still be in flight
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		// read it back in a second transfer
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_reg(idx, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] bgc, input logic [63:0] sx,
			input logic [63:0] sy, input logic [63:0] ms);
		drain_items();
		write_reg(REG_BG_CONTROLS, bgc);
		write_reg(REG_SCROLL_X, sx);
		write_reg(REG_SCROLL_Y, sy);
		write_reg(REG_MOSAIC, ms);
		no_idle = ($urandom_range(0, 3) == 0);
	endtask

	// Write whatever the fetch would read unwritten, then issue the query.
	task automatic fill_and_query(input logic [1:0] bg, input logic [7:0] px,
			input logic [7:0] py);
		result_t     res;
		bit          gap_pal;
		int          gap_addr, map_addr;
		logic [15:0] data;
		while (!sb.render_pixel(bg, px, py, res, gap_pal, gap_addr, map_addr)) begin
			data = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
			if (gap_pal)
				send_item(KIND_PAL_WR, 2'($urandom), 8'($urandom), 8'($urandom),
					{7'($urandom), 8'(gap_addr)}, data);
			else
				send_item(KIND_VRAM_WR, 2'($urandom), 8'($urandom), 8'($urandom),
					15'(gap_addr), data);
		end
		send_item(KIND_QUERY, bg, px, py, 15'($urandom), 16'($urandom));
		last_bg = bg;
		last_x = px;
		last_y = py;
	endtask

	task automatic random_item;
		result_t res;
		bit      gap_pal;
		int      gap_addr, map_addr;
		int      r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			fill_and_query(2'($urandom), 8'($urandom), 8'($urandom));
		end else if (r < 67) begin
			// overwrite the map entry of the last query and ask for that pixel again
			void'(sb.render_pixel(last_bg, last_x, last_y, res, gap_pal, gap_addr, map_addr));
			send_item(KIND_VRAM_WR, 2'($urandom), 8'($urandom), 8'($urandom),
				15'(map_addr), 16'($urandom));
			fill_and_query(last_bg, last_x, last_y);
		end else if (r < 82) begin
			send_item(KIND_VRAM_WR, 2'($urandom), 8'($urandom), 8'($urandom),
				15'($urandom), 16'($urandom));
		end else if (r < 94) begin
			send_item(KIND_PAL_WR, 2'($urandom), 8'($urandom), 8'($urandom),
				15'($urandom), 16'($urandom));
		end else begin
			send_item(KIND_UNUSED, 2'($urandom), 8'($urandom), 8'($urandom),
				15'($urandom), 16'($urandom));
		end
	endtask

	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: tile zero at map entry zero is all zeros, so the pixel is clear
		send_item(KIND_VRAM_WR, 2'd0, 8'd0, 8'd0, 15'd0, 16'h0000);
		send_item(KIND_QUERY, 2'd0, 8'd0, 8'd0, 15'd0, 16'h0000);
		send_item(KIND_UNUSED, '1, '1, '1, '1, '1);
		fill_and_query(2'd3, 8'd239, 8'd159);

		set_config('1, '1, '1, '1);
		fill_and_query(2'd3, 8'd0, 8'd0);
		fill_and_query(2'd0, 8'd255, 8'd255);
		send_item(KIND_VRAM_WR, 2'd0, 8'd0, 8'd0, 15'h7FFF, 16'hFFFF);
		send_item(KIND_PAL_WR, 2'd0, 8'd0, 8'd0, 15'h7FFF, 16'hFFFF);

		// one map size per background, both color depths, mosaic on two of them
		set_config({16'hC0C0, 16'h9F4B, 16'h4586, 16'h0001},
			64'({9'd511, 9'd256, 9'd255, 9'd1}), 64'({9'd0, 9'd300, 9'd17, 9'd511}), 64'h3B);
		fill_and_query(2'd1, 8'd0, 8'd0);
		fill_and_query(2'd2, 8'd100, 8'd50);
		fill_and_query(2'd3, 8'd239, 8'd159);

		while (items_sent < 2000) begin
			set_config(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value());
			repeat ($urandom_range(100, 300)) begin
				if (items_sent < 2000)
					random_item();
			end
		end

		drain_items();
		sb.close_out();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

### tiled_background_pixel_fetch.f
hw/rtl/tbpf_pkg.sv
hw/rtl/tbpf_ram.sv
hw/rtl/tbpf_front.sv
hw/rtl/tbpf_queue.sv
hw/rtl/tbpf_back.sv
hw/rtl/tiled_background_pixel_fetch.sv
sim/tb_top.sv
